// File: sv/wcs_pkg.sv
// Shared types, constants and helpers for the whitespace and comment skipper.
package wcs_pkg;

    // Width of the internal byte and newline counters.
    localparam int COUNT_BITS = 16;

    // Width of the count fields in a result.
    localparam int FIELD_BITS = 16;

    // Both counters stop at the lesser of the counter maximum and the field maximum.
    localparam longint unsigned LIMIT_INT = (COUNT_BITS >= FIELD_BITS) ?
        ((64'd1 << FIELD_BITS) - 64'd1) : ((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(LIMIT_INT);

    // Scan modes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_VOID  = 3'd1;
    localparam logic [2:0] MODE_SLASH = 3'd2;
    localparam logic [2:0] MODE_LINE  = 3'd3;
    localparam logic [2:0] MODE_BLOCK = 3'd4;
    localparam logic [2:0] MODE_STAR  = 3'd5;

    // Stop kinds.
    localparam logic STOP_BYTE = 1'b0;
    localparam logic STOP_END  = 1'b1;

    // Character codes.
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_scan;
        logic       last_byte;
    } wcs_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] void_length;
        logic [FIELD_BITS-1:0] line_delta;
        logic                  stop_kind;
    } wcs_result_t;

    // Saturating add of a small increment.
    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] v,
        input logic [1:0]            n
    );
        logic [COUNT_BITS:0] sum;
        begin
            sum = {1'b0, v} + {{(COUNT_BITS-1){1'b0}}, n};
            if (sum > {1'b0, COUNT_LIMIT})
            begin
                sat_add = COUNT_LIMIT;
            end
            else
            begin
                sat_add = sum[COUNT_BITS-1:0];
            end
        end
    endfunction

    // Counter value to result field; the value never exceeds the field maximum.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [COUNT_BITS-1:0] v);
        begin
            to_field = FIELD_BITS'(v);
        end
    endfunction

endpackage

// File: sv/wcs_scan.sv
// Scan state machine: mode and counters, updated once per accepted byte.
module wcs_scan
    import wcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  wcs_item_t   item,
    output logic        res_valid,
    output wcs_result_t res
);

    logic [2:0]            mode_reg, mode_next;
    logic [COUNT_BITS-1:0] len_reg, len_next;
    logic [COUNT_BITS-1:0] nl_reg, nl_next;

    logic [2:0]            mode_cur;
    logic [COUNT_BITS-1:0] len_cur, nl_cur;
    logic [1:0]            len_inc;
    logic                  nl_inc;
    logic                  stop_now;
    logic                  emit;
    logic                  blank;
    logic [7:0]            c;

    assign c = item.data_byte;

    always_comb
    begin
        blank = (c inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_CR});

        mode_cur = item.start_scan ? MODE_VOID : mode_reg;
        len_cur  = item.start_scan ? '0 : len_reg;
        nl_cur   = item.start_scan ? '0 : nl_reg;

        mode_next = mode_cur;
        len_inc   = 2'd0;
        nl_inc    = 1'b0;
        stop_now  = 1'b0;

        case (mode_cur)
            MODE_IDLE:
            begin
                mode_next = MODE_IDLE;
            end
            MODE_VOID:
            begin
                if (c == CHAR_NL)
                begin
                    len_inc = 2'd1;
                    nl_inc  = 1'b1;
                end
                else if (blank)
                begin
                    len_inc = 2'd1;
                end
                else if (c == CHAR_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else
                begin
                    stop_now = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (c == CHAR_SLASH)
                begin
                    len_inc   = 2'd2;
                    mode_next = MODE_LINE;
                end
                else if (c == CHAR_STAR)
                begin
                    len_inc   = 2'd2;
                    mode_next = MODE_BLOCK;
                end
                else
                begin
                    stop_now = 1'b1;
                end
            end
            MODE_LINE:
            begin
                len_inc = 2'd1;
                if (c == CHAR_NL)
                begin
                    nl_inc    = 1'b1;
                    mode_next = MODE_VOID;
                end
            end
            MODE_BLOCK:
            begin
                len_inc = 2'd1;
                if (c == CHAR_STAR)
                begin
                    mode_next = MODE_STAR;
                end
                else if (c == CHAR_NL)
                begin
                    nl_inc = 1'b1;
                end
            end
            MODE_STAR:
            begin
                len_inc = 2'd1;
                if (c == CHAR_SLASH)
                begin
                    mode_next = MODE_VOID;
                end
                else if (c == CHAR_NL)
                begin
                    nl_inc    = 1'b1;
                    mode_next = MODE_BLOCK;
                end
                else if (c != CHAR_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        len_next = sat_add(len_cur, len_inc);
        nl_next  = sat_add(nl_cur, {1'b0, nl_inc});

        // A held slash at the end of input is a lone slash and counts as a stop byte.
        res.void_length = to_field(len_next);
        res.line_delta  = to_field(nl_next);
        emit            = 1'b0;
        res.stop_kind   = STOP_BYTE;
        if (mode_cur != MODE_IDLE)
        begin
            if (stop_now)
            begin
                emit = 1'b1;
            end
            else if (item.last_byte)
            begin
                emit          = 1'b1;
                res.stop_kind = (mode_next == MODE_SLASH) ? STOP_BYTE : STOP_END;
            end
        end
        if (emit)
        begin
            mode_next = MODE_IDLE;
        end
    end

    assign res_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
            nl_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            nl_reg   <= nl_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= COUNT_LIMIT)
        else $error("length counter above its limit");

    a_nl_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        nl_reg <= len_reg)
        else $error("newline count exceeds byte count");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> mode_reg == MODE_IDLE)
        else $error("scan still running after its result");
`endif

endmodule

// File: sv/wcs_out.sv
// Two-entry output buffer: result register plus a skid register.
module wcs_out
    import wcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wcs_result_t push_data,
    output logic        can_accept,
    output logic        out_valid,
    input  logic        out_ready,
    output wcs_result_t out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    wcs_result_t out_reg;
    wcs_result_t skid_reg;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;
    assign can_accept = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a head entry");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result produced while the buffer is full");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && push) |=> skid_valid_reg)
        else $error("stalled result was not kept in the skid entry");
`endif

endmodule

// File: sv/whitespace_comment_skipper_top.sv
// Top level of the whitespace and comment skipper.
//
// Input stream: one source byte per transfer. s_tuser marks the byte that starts a
// new scan (counters cleared, any running scan dropped without a result); s_tlast
// marks the final byte of the input. Bytes that arrive with no scan running are
// absorbed without a result.
// Output stream: one transfer per scan, carrying the bytes of whitespace and
// comments consumed and the newlines among them, both saturating at 65535.
// m_tuser is 0 when the scan stopped before a byte it did not consume, 1 when the
// input ended. The result is registered. Throughput: one byte per cycle while
// s_tready is high; the mode and counter update is a single stage.
// When the receiver stalls, one further result fits in a skid register, and only
// once that is occupied does s_tready drop.
// Reset clears the scan mode, the counters and both result entries.
module whitespace_comment_skipper_top
    import wcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_scan
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] void_length, [31:16] line_delta
    output logic        m_tuser    // [0] stop_kind
);

    wcs_item_t   item;
    wcs_result_t res;
    wcs_result_t out_res;
    logic        res_valid;
    logic        accept;
    logic        can_accept;

    assign item.data_byte  = s_tdata;
    assign item.start_scan = s_tuser;
    assign item.last_byte  = s_tlast;

    assign s_tready = can_accept;
    assign accept   = s_tvalid && can_accept;

    wcs_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    wcs_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (can_accept),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {out_res.line_delta, out_res.void_length};
    assign m_tuser = out_res.stop_kind;

endmodule

// File: dv/tb_top.sv
// Testbench for the whitespace and comment skipper: directed table, random scans, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import wcs_pkg::*;

    localparam int LIVE_ITEM_GOAL  = 750;
    localparam int RESULT_GOAL     = 60;
    localparam int LONG_HOLD       = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PRINT_CAP       = 40;

    typedef struct packed {
        wcs_item_t   item;
        logic        pinned;
        wcs_result_t want;
    } probe_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // Shadow of the scan state.
    logic [2:0]            scan_mode_q = MODE_IDLE;
    logic [FIELD_BITS-1:0] run_len = '0;
    logic [FIELD_BITS-1:0] run_lines = '0;

    wcs_result_t scan_results[$];
    wcs_item_t   plan_q[$];
    probe_row_t  probe_rows[$];

    int mismatches = 0;
    int live_items = 0;
    int results_made = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int rx_hold_left = 0;
    int rx_span_left = 0;
    int rx_style = 0;
    int rx_phase = 0;

    whitespace_comment_skipper_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [FIELD_BITS-1:0] bump(input logic [FIELD_BITS-1:0] v,
                                                   input int unsigned n);
        longint unsigned sum;
        sum = v + n;
        if (sum > LIMIT_INT)
        begin
            return FIELD_BITS'(LIMIT_INT);
        end
        return FIELD_BITS'(sum);
    endfunction

    function automatic bit is_pad(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF ||
               c == CHAR_CR;
    endfunction

    function automatic logic [7:0] pick_pad();
        case ($urandom_range(0, 5))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            3: return CHAR_FF;
            4: return CHAR_CR;
            default: return CHAR_NL;
        endcase
    endfunction

    // A byte that stops a scan from the void state.
    function automatic logic [7:0] pick_hard();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_pad(c) || c == CHAR_NL || c == CHAR_SLASH);
        return c;
    endfunction

    // Block comment bodies lean on the characters that move the close detection.
    function automatic logic [7:0] pick_body();
        case ($urandom_range(0, 4))
            0: return CHAR_STAR;
            1: return CHAR_NL;
            2: return CHAR_SLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic probe_row_t free_row(input logic [7:0] c, input logic start,
                                            input logic last);
        return {c, start, last, 1'b0, 16'd0, 16'd0, 1'b0};
    endfunction

    function automatic probe_row_t fixed_row(input logic [7:0] c, input logic start,
                                             input logic last, input logic [15:0] len,
                                             input logic [15:0] lines, input logic kind);
        return {c, start, last, 1'b1, len, lines, kind};
    endfunction

    // Advances the shadow scan by one byte; fired is set when the scan closes.
    task automatic scan_step(input wcs_item_t it, output bit fired, output wcs_result_t res);
        logic [7:0] c;
        bit stop;
        c = it.data_byte;
        stop = 1'b0;
        fired = 1'b0;
        res = '0;
        if (it.start_scan)
        begin
            scan_mode_q = MODE_VOID;
            run_len = '0;
            run_lines = '0;
        end
        if (scan_mode_q != MODE_IDLE)
        begin
            case (scan_mode_q)
                MODE_VOID:
                begin
                    if (c == CHAR_NL)
                    begin
                        run_len = bump(run_len, 1);
                        run_lines = bump(run_lines, 1);
                    end
                    else if (is_pad(c))
                    begin
                        run_len = bump(run_len, 1);
                    end
                    else if (c == CHAR_SLASH)
                    begin
                        scan_mode_q = MODE_SLASH;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (c == CHAR_SLASH)
                    begin
                        run_len = bump(run_len, 2);
                        scan_mode_q = MODE_LINE;
                    end
                    else if (c == CHAR_STAR)
                    begin
                        run_len = bump(run_len, 2);
                        scan_mode_q = MODE_BLOCK;
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    run_len = bump(run_len, 1);
                    if (c == CHAR_NL)
                    begin
                        run_lines = bump(run_lines, 1);
                        scan_mode_q = MODE_VOID;
                    end
                end
                MODE_BLOCK:
                begin
                    run_len = bump(run_len, 1);
                    if (c == CHAR_STAR)
                    begin
                        scan_mode_q = MODE_STAR;
                    end
                    else if (c == CHAR_NL)
                    begin
                        run_lines = bump(run_lines, 1);
                    end
                end
                default:
                begin
                    run_len = bump(run_len, 1);
                    if (c == CHAR_SLASH)
                    begin
                        scan_mode_q = MODE_VOID;
                    end
                    else if (c == CHAR_NL)
                    begin
                        run_lines = bump(run_lines, 1);
                        scan_mode_q = MODE_BLOCK;
                    end
                    else if (c != CHAR_STAR)
                    begin
                        scan_mode_q = MODE_BLOCK;
                    end
                end
            endcase
            if (stop || it.last_byte)
            begin
                fired = 1'b1;
                res.void_length = run_len;
                res.line_delta = run_lines;
                // A slash still held at the end of input counts as a lone slash.
                res.stop_kind = (stop || scan_mode_q == MODE_SLASH) ? STOP_BYTE : STOP_END;
                scan_mode_q = MODE_IDLE;
            end
        end
    endtask

    // Offers one byte from a falling edge and returns at the falling edge after its transfer.
    task automatic push_byte(input wcs_item_t it, input bit pinned, input wcs_result_t pin_res);
        bit fired;
        wcs_result_t res;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= it.data_byte;
        s_tuser  <= it.start_scan;
        s_tlast  <= it.last_byte;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (it.start_scan || scan_mode_q != MODE_IDLE)
        begin
            live_items++;
        end
        scan_step(it, fired, res);
        if (pinned)
        begin
            scan_results.push_back(pin_res);
            results_made++;
        end
        else if (fired)
        begin
            scan_results.push_back(res);
            results_made++;
        end
        @(negedge clk);
    endtask

    task automatic plan_byte(input logic [7:0] c);
        plan_q.push_back({c, 1'b0, 1'b0});
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
        begin
            $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        wcs_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (scan_results.size() == 0)
            begin
                report_mismatch("unexpected transfer, void_length", m_tdata[15:0], 0);
            end
            else
            begin
                want = scan_results.pop_front();
                if (m_tdata[15:0] != want.void_length)
                begin
                    report_mismatch("void_length", m_tdata[15:0], want.void_length);
                end
                if (m_tdata[31:16] != want.line_delta)
                begin
                    report_mismatch("line_delta", m_tdata[31:16], want.line_delta);
                end
                if (m_tuser != want.stop_kind)
                begin
                    report_mismatch("stop_kind", m_tuser, want.stop_kind);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: stretches of differing stall styles, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            rx_hold_left = LONG_HOLD;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_span_left == 0)
            begin
                rx_style = $urandom_range(0, 3);
                rx_span_left = $urandom_range(8, 120);
            end
            rx_span_left--;
            rx_phase++;
            case (rx_style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_phase % 3) != 0;
                default: m_tready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    initial
    begin
        int ntok;
        int ending;
        logic [7:0] c;
        probe_rows = '{
            free_row(8'h41, 1'b0, 1'b0),                      // no scan running: ignored
            fixed_row(8'h41, 1'b1, 1'b1, 16'd0, 16'd0, STOP_BYTE),
            fixed_row(CHAR_SPACE, 1'b1, 1'b1, 16'd1, 16'd0, STOP_END),
            free_row(CHAR_SPACE, 1'b1, 1'b0),
            free_row(CHAR_TAB, 1'b0, 1'b0),
            free_row(CHAR_VT, 1'b0, 1'b0),
            free_row(CHAR_FF, 1'b0, 1'b0),
            free_row(CHAR_CR, 1'b0, 1'b0),
            free_row(CHAR_NL, 1'b0, 1'b0),
            free_row(CHAR_SLASH, 1'b0, 1'b0),
            free_row(CHAR_SLASH, 1'b0, 1'b0),
            free_row(8'hFF, 1'b0, 1'b0),
            free_row(CHAR_NL, 1'b0, 1'b0),
            free_row(CHAR_SLASH, 1'b0, 1'b0),
            free_row(CHAR_STAR, 1'b0, 1'b0),
            free_row(CHAR_SLASH, 1'b0, 1'b0),                 // opener star cannot close
            free_row(CHAR_STAR, 1'b0, 1'b0),
            free_row(CHAR_NL, 1'b0, 1'b0),
            free_row(CHAR_STAR, 1'b0, 1'b0),
            free_row(CHAR_STAR, 1'b0, 1'b0),
            free_row(CHAR_SLASH, 1'b0, 1'b0),
            free_row(CHAR_SLASH, 1'b0, 1'b1),                 // held slash at end of input
            free_row(CHAR_SPACE, 1'b1, 1'b0),                 // dropped by the next start
            fixed_row(8'h00, 1'b1, 1'b0, 16'd0, 16'd0, STOP_BYTE),
            free_row(CHAR_SLASH, 1'b1, 1'b0),
            free_row(CHAR_STAR, 1'b0, 1'b1),                  // unclosed block comment
            free_row(CHAR_SLASH, 1'b1, 1'b0),
            free_row(8'h80, 1'b0, 1'b0)                       // lone slash
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probe_rows[i])
        begin
            push_byte(probe_rows[i].item, probe_rows[i].pinned, probe_rows[i].want);
        end

        live_items = 0;
        results_made = 0;
        hold_request = 1'b1;
        while (live_items < LIVE_ITEM_GOAL || results_made < RESULT_GOAL)
        begin
            plan_q.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    c = 8'($urandom_range(0, 255));
                    plan_q.push_back({c, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0});
                end
            end
            else
            begin
                ntok = $urandom_range(0, 5);
                repeat (ntok)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            repeat ($urandom_range(1, 4)) plan_byte(pick_pad());
                        end
                        1:
                        begin
                            plan_byte(CHAR_SLASH);
                            plan_byte(CHAR_SLASH);
                            repeat ($urandom_range(0, 6)) plan_byte(8'($urandom_range(0, 255)));
                            plan_byte(CHAR_NL);
                        end
                        2:
                        begin
                            plan_byte(CHAR_SLASH);
                            plan_byte(CHAR_STAR);
                            repeat ($urandom_range(0, 6)) plan_byte(pick_body());
                            plan_byte(CHAR_STAR);
                            plan_byte(CHAR_SLASH);
                        end
                        default: plan_byte(CHAR_NL);
                    endcase
                end
                ending = $urandom_range(0, 7);
                case (ending)
                    0, 1, 2: plan_byte(pick_hard());
                    3:
                    begin
                        plan_byte(CHAR_SLASH);
                        do
                        begin
                            c = 8'($urandom_range(0, 255));
                        end
                        while (c == CHAR_SLASH || c == CHAR_STAR);
                        plan_byte(c);
                    end
                    4: plan_byte(CHAR_SLASH);
                    5, 6: ;
                    default:
                    begin
                        plan_byte(CHAR_SLASH);
                        plan_byte(CHAR_STAR);
                        repeat ($urandom_range(0, 4)) plan_byte(pick_body());
                    end
                endcase
                if (plan_q.size() == 0)
                begin
                    plan_byte(pick_pad());
                end
                plan_q[0].start_scan = 1'b1;
                // Ending six leaves the scan open so that the next start drops it.
                if (ending == 4 || ending == 5 || ending == 7 ||
                    (ending != 6 && $urandom_range(0, 5) == 0))
                begin
                    plan_q[plan_q.size() - 1].last_byte = 1'b1;
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 3)) plan_byte(8'($urandom_range(0, 255)));
                end
            end
            foreach (plan_q[i])
            begin
                push_byte(plan_q[i], 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (scan_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
